FILE: sv/frp_pkg.sv
// Package for the feature vector record parser.
// Result payload type and the fixed constants of the response layout.
// No dependencies.
`timescale 1ns / 1ps

package frp_pkg;

   localparam int POS_W = 7;   // byte position within one read
   localparam int LEN_W = 9;   // packet length and header position
   localparam int GRP_W = 6;   // group counts within one record
   localparam int CNT_W = 8;   // vector count and limit

   localparam logic [POS_W-1:0] LEN_POS    = 7'd3;  // byte that carries the length
   localparam logic [POS_W-1:0] REC_FIRST  = 7'd6;  // first record header
   localparam logic [LEN_W-1:0] LEN_BIAS   = 9'd4;
   localparam logic [LEN_W-1:0] HDR_FIRST  = 9'd6;
   localparam logic [2:0]       GRP_LAST   = 3'd5;  // last offset in a 6-byte group
   localparam logic [2:0]       VEC_LAST   = 3'd3;  // last emitted offset in a group
   localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd16;

   typedef struct packed {
      logic             vector_valid;
      logic [7:0]       x_start;
      logic [7:0]       y_start;
      logic [7:0]       x_end;
      logic [7:0]       y_end;
      logic             done_res;
      logic [CNT_W-1:0] vector_total;
   } rsp_payload_type;

endpackage

FILE: sv/frp_req_if.sv
// Request channel: one response byte per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface frp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_read;

   modport source (output valid, output rx_byte, output end_of_read, input ready);
   modport sink   (input valid, input rx_byte, input end_of_read, output ready);
endinterface

FILE: sv/frp_rsp_if.sv
// Result channel: one vector and/or done beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface frp_rsp_if;
   logic       valid;
   logic       ready;
   logic       vector_valid;
   logic [7:0] x_start;
   logic [7:0] y_start;
   logic [7:0] x_end;
   logic [7:0] y_end;
   logic       done_res;
   logic [7:0] vector_total;

   modport source (output valid, output vector_valid, output x_start, output y_start,
                   output x_end, output y_end, output done_res, output vector_total,
                   input ready);
   modport sink   (input valid, input vector_valid, input x_start, input y_start,
                   input x_end, input y_end, input done_res, input vector_total,
                   output ready);
endinterface

FILE: sv/feature_vector_record_parser.sv
// Feature vector record parser top level.
// Depends on frp_pkg, frp_req_if and frp_rsp_if.
`timescale 1ns / 1ps

// Takes one response byte per cycle while ready is high and parses
// type-length-value records on the fly: byte 3 gives the packet length,
// records start at byte 6, and the first four bytes of every whole 6-byte
// group of record data go out as one vector beat on the byte that completes
// it. The last byte of a read (flagged, or byte READ_BYTES-1) gives a done
// beat carrying the vector count, after which the parser is back at byte 0.
// Parsing is one pass of logic per byte, so the block takes a byte every
// cycle while ready is high; a result is registered in the output buffer as
// its byte is accepted. A two-entry output buffer keeps req_bus.ready high
// while one result waits; ready drops only when both entries are full.
// csr_write_data sets the vector limit (reset 16); write it between reads.
module feature_vector_record_parser #(
   parameter int READ_BYTES = 100
) (
   input  logic       clock,
   input  logic       reset,
   frp_req_if.sink    req_bus,
   frp_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam logic [frp_pkg::POS_W-1:0] LAST_POS = frp_pkg::POS_W'(READ_BYTES - 1);

   logic [frp_pkg::CNT_W-1:0] limit_ff;
   logic [frp_pkg::POS_W-1:0] pos_ff,     pos_in;
   logic [frp_pkg::LEN_W-1:0] pkt_len_ff, pkt_len_in;
   logic [frp_pkg::LEN_W-1:0] hdr_pos_ff, hdr_pos_in;
   logic                      rec_open_ff, rec_open_in;
   logic [frp_pkg::GRP_W-1:0] groups_ff,  groups_in;
   logic [frp_pkg::GRP_W-1:0] grp_ff,     grp_in;
   logic [2:0]                off_ff,     off_in;
   logic                      stopped_ff, stopped_in;
   logic [frp_pkg::CNT_W-1:0] count_ff,   count_in;
   logic [7:0]                vb_ff [3];
   logic [7:0]                vb_in [3];

   frp_pkg::rsp_payload_type  main_ff, main_in, skid_ff, skid_in, new_rsp;
   logic                      main_vld_ff, main_vld_in, skid_vld_ff, skid_vld_in;

   logic                      accept, last, emit, new_vld;
   logic                      in_data, hdr_len_byte, open_rec;
   logic [frp_pkg::LEN_W-1:0] pos_ext;
   logic [15:0]               div_prod;

   assign accept  = req_bus.valid & req_bus.ready;
   assign pos_ext = {2'b00, pos_ff};
   // b / 6 as b * 171 >> 10, exact for 8-bit b
   assign div_prod = 16'(req_bus.rx_byte) * 16'd171;

   always_comb begin
      last         = req_bus.end_of_read | (pos_ff == LAST_POS);
      emit         = 1'b0;
      open_rec     = 1'b0;
      in_data      = rec_open_ff & (pos_ext < hdr_pos_ff);
      hdr_len_byte = ~in_data & (pos_ext == hdr_pos_ff + 9'd1);

      pkt_len_in  = pkt_len_ff;
      hdr_pos_in  = hdr_pos_ff;
      rec_open_in = rec_open_ff;
      groups_in   = groups_ff;
      stopped_in  = stopped_ff;
      count_in    = count_ff;
      vb_in       = vb_ff;

      if (pos_ff == frp_pkg::LEN_POS) begin
         pkt_len_in = {1'b0, req_bus.rx_byte} + frp_pkg::LEN_BIAS;
      end

      if (!stopped_ff && pos_ff >= frp_pkg::REC_FIRST) begin
         if (in_data) begin
            if (grp_ff < groups_ff && off_ff <= frp_pkg::VEC_LAST) begin
               if (off_ff == frp_pkg::VEC_LAST) begin
                  if (count_ff < limit_ff) begin
                     emit     = 1'b1;
                     count_in = count_ff + 8'd1;
                  end else begin
                     stopped_in = 1'b1;
                  end
               end else begin
                  vb_in[off_ff[1:0]] = req_bus.rx_byte;
               end
            end
         end else if (hdr_len_byte) begin
            if (!({1'b0, hdr_pos_ff} + 10'd1 < {1'b0, pkt_len_ff}) ||
                count_ff >= limit_ff) begin
               stopped_in = 1'b1;
            end else begin
               open_rec    = 1'b1;
               rec_open_in = 1'b1;
               groups_in   = div_prod[15:10];
               hdr_pos_in  = hdr_pos_ff + 9'd2 + {1'b0, req_bus.rx_byte};
            end
         end
      end

      // offset within the current record's data, kept as group and byte-in-group
      if (open_rec) begin
         off_in = 3'd0;
         grp_in = '0;
      end else if (off_ff == frp_pkg::GRP_LAST) begin
         off_in = 3'd0;
         grp_in = grp_ff + 6'd1;
      end else begin
         off_in = off_ff + 3'd1;
         grp_in = grp_ff;
      end
      pos_in = pos_ff + 7'd1;

      new_vld              = emit | last;
      new_rsp.vector_valid = emit;
      new_rsp.x_start      = emit ? vb_ff[0] : 8'd0;
      new_rsp.y_start      = emit ? vb_ff[1] : 8'd0;
      new_rsp.x_end        = emit ? vb_ff[2] : 8'd0;
      new_rsp.y_end        = emit ? req_bus.rx_byte : 8'd0;
      new_rsp.done_res     = last;
      new_rsp.vector_total = count_in;

      if (last) begin
         pos_in      = '0;
         pkt_len_in  = '0;
         hdr_pos_in  = frp_pkg::HDR_FIRST;
         rec_open_in = 1'b0;
         groups_in   = '0;
         grp_in      = '0;
         off_in      = 3'd0;
         stopped_in  = 1'b0;
         count_in    = '0;
         vb_in[0]    = 8'd0;
         vb_in[1]    = 8'd0;
         vb_in[2]    = 8'd0;
      end
   end

   // two-entry output buffer: main drives the port, skid catches a beat
   // produced while main is stalled
   always_comb begin
      main_in     = main_ff;
      skid_in     = skid_ff;
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (!main_vld_ff || rsp_bus.ready) begin
         if (skid_vld_ff) begin
            main_in     = skid_ff;
            main_vld_in = 1'b1;
            skid_in     = new_rsp;
            skid_vld_in = accept & new_vld;
         end else begin
            main_in     = new_rsp;
            main_vld_in = accept & new_vld;
         end
      end else if (accept && new_vld) begin
         skid_in     = new_rsp;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= frp_pkg::LIMIT_RESET;
         pos_ff      <= '0;
         pkt_len_ff  <= '0;
         hdr_pos_ff  <= frp_pkg::HDR_FIRST;
         rec_open_ff <= 1'b0;
         groups_ff   <= '0;
         grp_ff      <= '0;
         off_ff      <= 3'd0;
         stopped_ff  <= 1'b0;
         count_ff    <= '0;
         vb_ff[0]    <= 8'd0;
         vb_ff[1]    <= 8'd0;
         vb_ff[2]    <= 8'd0;
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (accept) begin
            pos_ff      <= pos_in;
            pkt_len_ff  <= pkt_len_in;
            hdr_pos_ff  <= hdr_pos_in;
            rec_open_ff <= rec_open_in;
            groups_ff   <= groups_in;
            grp_ff      <= grp_in;
            off_ff      <= off_in;
            stopped_ff  <= stopped_in;
            count_ff    <= count_in;
            vb_ff       <= vb_in;
         end
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign req_bus.ready        = ~skid_vld_ff;
   assign rsp_bus.valid        = main_vld_ff;
   assign rsp_bus.vector_valid = main_ff.vector_valid;
   assign rsp_bus.x_start      = main_ff.x_start;
   assign rsp_bus.y_start      = main_ff.y_start;
   assign rsp_bus.x_end        = main_ff.x_end;
   assign rsp_bus.y_end        = main_ff.y_end;
   assign rsp_bus.done_res     = main_ff.done_res;
   assign rsp_bus.vector_total = main_ff.vector_total;

endmodule
